// ===== design/rmie_pkg.sv =====
// Shared types, command codes and constants for real-mode interrupt entry and return.
package rmie_pkg;

	// Memory geometry
	localparam int ADDR_BITS = 20;
	localparam int MEM_DEPTH = 2 ** ADDR_BITS;
	localparam int PHYS_BITS = 20;

	// Command codes
	localparam logic [2:0] CMD_INT   = 3'd0;
	localparam logic [2:0] CMD_IRET  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_LOAD  = 3'd4;

	// Architectural constants
	localparam logic [15:0] FLAGS_CLR_MASK = 16'hFCFF;
	localparam logic [15:0] CS_CARRY       = 16'h1000;
	localparam logic [7:0]  BRK_VECTOR     = 8'd3;

	// Stack pointer operations
	localparam logic [1:0] SP_HOLD = 2'd0;
	localparam logic [1:0] SP_DEC  = 2'd1;
	localparam logic [1:0] SP_INC  = 2'd2;

	// Memory address sources
	localparam logic [1:0] AS_STACK = 2'd0;
	localparam logic [1:0] AS_VEC   = 2'd1;
	localparam logic [1:0] AS_CMD   = 2'd2;

	// Write data sources
	localparam logic [1:0] WS_FLAGS = 2'd0;
	localparam logic [1:0] WS_CS    = 2'd1;
	localparam logic [1:0] WS_IP    = 2'd2;
	localparam logic [1:0] WS_DATA  = 2'd3;

	// Word load targets
	localparam logic [1:0] WD_NONE = 2'd0;
	localparam logic [1:0] WD_IP   = 2'd1;
	localparam logic [1:0] WD_CS   = 2'd2;
	localparam logic [1:0] WD_FL   = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  vector;
		logic [19:0] address;
		logic [7:0]  data_byte;
		logic [15:0] new_stack_segment;
		logic [15:0] new_stack_pointer;
		logic [15:0] new_code_segment;
		logic [15:0] new_instruction_pointer;
		logic [15:0] new_flags;
	} req_t;

	typedef struct packed {
		logic [15:0] stack_segment_out;
		logic [15:0] stack_pointer_out;
		logic [15:0] code_segment_out;
		logic [15:0] instruction_pointer_out;
		logic [15:0] flags_out;
		logic [7:0]  read_byte;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic       req_ld;
		logic       rd_clr;
		logic       load_regs;
		logic       ip_adv;
		logic [1:0] sp_op;
		logic       flags_clr;
		logic       mem_we;
		logic       mem_re;
		logic [1:0] addr_sel;
		logic [1:0] addr_off;
		logic [1:0] wsrc;
		logic       whi;
		logic       tmp_ld;
		logic [1:0] word_ld;
		logic       rd_ld;
		logic       rsp_ld;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rsp_full;
	} dp_sts_t;

endpackage

// ===== design/rmie_datapath.sv =====
// Register file, byte memory, address and data steering, and result register.
module rmie_datapath import rmie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t dp_cmd,
	output dp_sts_t dp_sts,
	output rsp_t    rsp,
	output logic    rsp_valid,
	input  logic    rsp_ready
);

	req_t                 req_q;
	logic [15:0]          ss_q;
	logic [15:0]          sp_q;
	logic [15:0]          cs_q;
	logic [15:0]          ip_q;
	logic [15:0]          fl_q;
	logic [7:0]           tmp_q;
	logic [7:0]           rd_q;
	logic [7:0]           rdata_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [7:0]           mem_q [0:MEM_DEPTH-1];

	logic [PHYS_BITS-1:0] stack_sum;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [15:0]          wword;
	logic [7:0]           wbyte;
	logic [16:0]          ip_sum;
	logic [15:0]          rword;

	// Form the stack address with its byte offset
	assign stack_sum = {ss_q, 4'b0000} + {4'b0000, sp_q} + {18'b0, dp_cmd.addr_off};

	always_comb begin
		case (dp_cmd.addr_sel)
			AS_STACK: mem_addr = stack_sum[ADDR_BITS-1:0];
			AS_VEC:   mem_addr = {{(ADDR_BITS-10){1'b0}}, req_q.vector, dp_cmd.addr_off};
			AS_CMD:   mem_addr = req_q.address[ADDR_BITS-1:0];
			default:  mem_addr = req_q.address[ADDR_BITS-1:0];
		endcase
	end

	// Pick the word and byte to store
	always_comb begin
		case (dp_cmd.wsrc)
			WS_FLAGS: wword = fl_q;
			WS_CS:    wword = cs_q;
			WS_IP:    wword = ip_q;
			WS_DATA:  wword = {8'h00, req_q.data_byte};
			default:  wword = fl_q;
		endcase
		wbyte = dp_cmd.whi ? wword[15:8] : wword[7:0];
	end

	// Return address advance: one past a breakpoint, two past any other vector
	assign ip_sum = {1'b0, ip_q} + ((req_q.vector == BRK_VECTOR) ? 17'd1 : 17'd2);
	assign rword  = {rdata_q, tmp_q};

	// Byte memory, one port
	always_ff @(posedge clk) begin
		if (dp_cmd.mem_we) begin
			mem_q[mem_addr] <= wbyte;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	// Hold the accepted transaction and the low byte of a word being read
	always_ff @(posedge clk) begin
		if (dp_cmd.req_ld) begin
			req_q <= req;
		end
		if (dp_cmd.tmp_ld) begin
			tmp_q <= rdata_q;
		end
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q <= '0;
			sp_q <= '0;
			cs_q <= '0;
			ip_q <= '0;
			fl_q <= '0;
			rd_q <= '0;
		end else begin
			if (dp_cmd.load_regs) begin
				ss_q <= req_q.new_stack_segment;
				sp_q <= req_q.new_stack_pointer;
				cs_q <= req_q.new_code_segment;
				ip_q <= req_q.new_instruction_pointer;
				fl_q <= req_q.new_flags;
			end
			if (dp_cmd.ip_adv) begin
				ip_q <= ip_sum[15:0];
				if (ip_sum[16]) begin
					cs_q <= cs_q + CS_CARRY;
				end
			end
			if (dp_cmd.flags_clr) begin
				fl_q <= fl_q & FLAGS_CLR_MASK;
			end
			case (dp_cmd.word_ld)
				WD_IP:   ip_q <= rword;
				WD_CS:   cs_q <= rword;
				WD_FL:   fl_q <= rword;
				default: ;
			endcase
			case (dp_cmd.sp_op)
				SP_DEC:  sp_q <= sp_q - 16'd2;
				SP_INC:  sp_q <= sp_q + 16'd2;
				default: ;
			endcase
			if (dp_cmd.rd_clr) begin
				rd_q <= '0;
			end else if (dp_cmd.rd_ld) begin
				rd_q <= rdata_q;
			end
		end
	end

	// Result register and its valid bit
	always_ff @(posedge clk) begin
		if (dp_cmd.rsp_ld) begin
			rsp_q.stack_segment_out       <= ss_q;
			rsp_q.stack_pointer_out       <= sp_q;
			rsp_q.code_segment_out        <= cs_q;
			rsp_q.instruction_pointer_out <= ip_q;
			rsp_q.flags_out               <= fl_q;
			rsp_q.read_byte               <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.rsp_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp             = rsp_q;
	assign rsp_valid       = rsp_valid_q;
	assign dp_sts.rsp_full = rsp_valid_q & ~rsp_ready;

endmodule

// ===== design/rmie_ctrl.sv =====
// Sequencer that steps each command through its memory and register operations.
module rmie_ctrl import rmie_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [2:0] req_cmd,
	output logic       req_ready,
	output dp_cmd_t    dp_cmd,
	input  dp_sts_t    dp_sts
);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_INT_ADV  = 5'd1;
	localparam logic [4:0] ST_PF_LO    = 5'd2;
	localparam logic [4:0] ST_PF_HI    = 5'd3;
	localparam logic [4:0] ST_PC_LO    = 5'd4;
	localparam logic [4:0] ST_PC_HI    = 5'd5;
	localparam logic [4:0] ST_PI_LO    = 5'd6;
	localparam logic [4:0] ST_PI_HI    = 5'd7;
	localparam logic [4:0] ST_VEC0     = 5'd8;
	localparam logic [4:0] ST_VEC1     = 5'd9;
	localparam logic [4:0] ST_VEC2     = 5'd10;
	localparam logic [4:0] ST_VEC3     = 5'd11;
	localparam logic [4:0] ST_VEC_FIN  = 5'd12;
	localparam logic [4:0] ST_POP_LO   = 5'd13;
	localparam logic [4:0] ST_POP_HI   = 5'd14;
	localparam logic [4:0] ST_POP_FIN  = 5'd15;
	localparam logic [4:0] ST_WRITE    = 5'd16;
	localparam logic [4:0] ST_READ     = 5'd17;
	localparam logic [4:0] ST_READ_CAP = 5'd18;
	localparam logic [4:0] ST_LOAD     = 5'd19;
	localparam logic [4:0] ST_DONE     = 5'd20;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [1:0] pop_q;
	logic [1:0] pop_d;

	// Decode state into datapath commands
	always_comb begin
		state_d   = state_q;
		pop_d     = pop_q;
		req_ready = 1'b0;
		dp_cmd    = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dp_cmd.req_ld = 1'b1;
					dp_cmd.rd_clr = 1'b1;
					case (req_cmd)
						CMD_INT:   state_d = ST_INT_ADV;
						CMD_IRET: begin
							state_d = ST_POP_LO;
							pop_d   = WD_IP;
						end
						CMD_WRITE: state_d = ST_WRITE;
						CMD_READ:  state_d = ST_READ;
						CMD_LOAD:  state_d = ST_LOAD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			// Advance the return address and make room for FLAGS
			ST_INT_ADV: begin
				dp_cmd.ip_adv = 1'b1;
				dp_cmd.sp_op  = SP_DEC;
				state_d       = ST_PF_LO;
			end
			ST_PF_LO: begin
				dp_cmd.mem_we = 1'b1;
				dp_cmd.wsrc   = WS_FLAGS;
				state_d       = ST_PF_HI;
			end
			ST_PF_HI: begin
				dp_cmd.mem_we   = 1'b1;
				dp_cmd.wsrc     = WS_FLAGS;
				dp_cmd.whi      = 1'b1;
				dp_cmd.addr_off = 2'd1;
				dp_cmd.sp_op    = SP_DEC;
				state_d         = ST_PC_LO;
			end
			ST_PC_LO: begin
				dp_cmd.mem_we = 1'b1;
				dp_cmd.wsrc   = WS_CS;
				state_d       = ST_PC_HI;
			end
			ST_PC_HI: begin
				dp_cmd.mem_we   = 1'b1;
				dp_cmd.wsrc     = WS_CS;
				dp_cmd.whi      = 1'b1;
				dp_cmd.addr_off = 2'd1;
				dp_cmd.sp_op    = SP_DEC;
				state_d         = ST_PI_LO;
			end
			ST_PI_LO: begin
				dp_cmd.mem_we = 1'b1;
				dp_cmd.wsrc   = WS_IP;
				state_d       = ST_PI_HI;
			end
			// Last push; drop TF and IF
			ST_PI_HI: begin
				dp_cmd.mem_we    = 1'b1;
				dp_cmd.wsrc      = WS_IP;
				dp_cmd.whi       = 1'b1;
				dp_cmd.addr_off  = 2'd1;
				dp_cmd.flags_clr = 1'b1;
				state_d          = ST_VEC0;
			end
			// Fetch the vector table entry, one byte a cycle
			ST_VEC0: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_sel = AS_VEC;
				state_d         = ST_VEC1;
			end
			ST_VEC1: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_sel = AS_VEC;
				dp_cmd.addr_off = 2'd1;
				dp_cmd.tmp_ld   = 1'b1;
				state_d         = ST_VEC2;
			end
			ST_VEC2: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_sel = AS_VEC;
				dp_cmd.addr_off = 2'd2;
				dp_cmd.word_ld  = WD_IP;
				state_d         = ST_VEC3;
			end
			ST_VEC3: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_sel = AS_VEC;
				dp_cmd.addr_off = 2'd3;
				dp_cmd.tmp_ld   = 1'b1;
				state_d         = ST_VEC_FIN;
			end
			ST_VEC_FIN: begin
				dp_cmd.word_ld = WD_CS;
				state_d        = ST_DONE;
			end
			// Pop IP, CS and FLAGS in turn
			ST_POP_LO: begin
				dp_cmd.mem_re = 1'b1;
				state_d       = ST_POP_HI;
			end
			ST_POP_HI: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_off = 2'd1;
				dp_cmd.tmp_ld   = 1'b1;
				state_d         = ST_POP_FIN;
			end
			ST_POP_FIN: begin
				dp_cmd.word_ld = pop_q;
				dp_cmd.sp_op   = SP_INC;
				if (pop_q == WD_FL) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_POP_LO;
					pop_d   = (pop_q == WD_IP) ? WD_CS : WD_FL;
				end
			end
			ST_WRITE: begin
				dp_cmd.mem_we   = 1'b1;
				dp_cmd.addr_sel = AS_CMD;
				dp_cmd.wsrc     = WS_DATA;
				state_d         = ST_DONE;
			end
			ST_READ: begin
				dp_cmd.mem_re   = 1'b1;
				dp_cmd.addr_sel = AS_CMD;
				state_d         = ST_READ_CAP;
			end
			ST_READ_CAP: begin
				dp_cmd.rd_ld = 1'b1;
				state_d      = ST_DONE;
			end
			ST_LOAD: begin
				dp_cmd.load_regs = 1'b1;
				state_d          = ST_DONE;
			end
			// Hand the result over once the result register is free
			ST_DONE: begin
				if (!dp_sts.rsp_full) begin
					dp_cmd.rsp_ld = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pop_q   <= WD_IP;
		end else begin
			state_q <= state_d;
			pop_q   <= pop_d;
		end
	end

endmodule

// ===== design/real_mode_interrupt_entry_return.sv =====
// Top level of real-mode interrupt entry and return over a byte memory.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------
//   request  | req_valid / req_ready   | req (command, vector, address, data, loads)
//   result   | rsp_valid / rsp_ready   | rsp (SS, SP, CS, IP, FLAGS, read byte)
//
// One transaction at a time; the single memory port sets the pace. An interrupt takes six byte
// pushes and four vector byte reads, a return six byte pops. The next request is taken in the
// cycle after the result is loaded. Reset clears SS, SP, CS, IP and FLAGS; memory is not
// cleared. A stalled result holds the sequencer in its last step only.
module real_mode_interrupt_entry_return import rmie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	rmie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	rmie_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	// No second transaction is taken right behind one just accepted
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a command is in progress");

	// A result appears only at the end of a command, never from idle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result raised while the sequencer was idle");

endmodule

// ===== tb/rmie_result_checker.sv =====
// Result checker for real-mode interrupt entry and return: predicts each result and compares it.
module rmie_result_checker import rmie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   pending,
	output int   compared
);

	// Architectural registers and byte memory as the block should hold them
	logic [15:0] arch_ss;
	logic [15:0] arch_sp;
	logic [15:0] arch_cs;
	logic [15:0] arch_ip;
	logic [15:0] arch_fl;
	logic [7:0]  mem_image [bit [19:0]];

	// Register images still owed by the block, oldest first
	rsp_t expected_images [$];
	rsp_t oldest;

	function automatic logic [7:0] mem_byte(input logic [19:0] a);
		if (mem_image.exists(a))
			return mem_image[a];
		return 8'h00;
	endfunction

	function automatic logic [15:0] fetch_word(input logic [19:0] a);
		return {mem_byte(a + 20'd1), mem_byte(a)};
	endfunction

	function automatic logic [19:0] stack_top();
		return {arch_ss, 4'h0} + {4'h0, arch_sp};
	endfunction

	function automatic void push_word(input logic [15:0] w);
		logic [19:0] a;
		arch_sp = arch_sp - 16'd2;
		a = stack_top();
		mem_image[a] = w[7:0];
		a = a + 20'd1;
		mem_image[a] = w[15:8];
	endfunction

	function automatic logic [15:0] pop_word();
		logic [15:0] w;
		w = fetch_word(stack_top());
		arch_sp = arch_sp + 16'd2;
		return w;
	endfunction

	// Apply one command to the architectural state and return the register image after it
	function automatic rsp_t predict_registers(input req_t r);
		rsp_t        img;
		logic [16:0] next_ip;
		logic [19:0] vec_base;
		img = '0;
		case (r.cmd)
			CMD_INT: begin
				next_ip = {1'b0, arch_ip} + ((r.vector == BRK_VECTOR) ? 17'd1 : 17'd2);
				push_word(arch_fl);
				// carry out of IP bumps CS by one 64K segment
				if (next_ip[16])
					arch_cs = arch_cs + CS_CARRY;
				arch_ip = next_ip[15:0];
				push_word(arch_cs);
				push_word(arch_ip);
				arch_fl = arch_fl & FLAGS_CLR_MASK;
				vec_base = {10'd0, r.vector, 2'b00};
				arch_ip = fetch_word(vec_base);
				arch_cs = fetch_word(vec_base + 20'd2);
			end
			CMD_IRET: begin
				arch_ip = pop_word();
				arch_cs = pop_word();
				arch_fl = pop_word();
			end
			CMD_WRITE: mem_image[r.address] = r.data_byte;
			CMD_READ:  img.read_byte = mem_byte(r.address);
			CMD_LOAD: begin
				arch_ss = r.new_stack_segment;
				arch_sp = r.new_stack_pointer;
				arch_cs = r.new_code_segment;
				arch_ip = r.new_instruction_pointer;
				arch_fl = r.new_flags;
			end
			default: ;
		endcase
		img.stack_segment_out       = arch_ss;
		img.stack_pointer_out       = arch_sp;
		img.code_segment_out        = arch_cs;
		img.instruction_pointer_out = arch_ip;
		img.flags_out               = arch_fl;
		return img;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Retire results against the oldest prediction, then predict newly accepted commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_ss = '0;
			arch_sp = '0;
			arch_cs = '0;
			arch_ip = '0;
			arch_fl = '0;
			expected_images.delete();
			mismatches = 0;
			pending = 0;
			compared = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_images.size() == 0) begin
					$error("result transaction with no command outstanding");
					mismatches++;
				end else begin
					oldest = expected_images.pop_front();
					check_field("stack_segment_out", oldest.stack_segment_out,
						rsp.stack_segment_out);
					check_field("stack_pointer_out", oldest.stack_pointer_out,
						rsp.stack_pointer_out);
					check_field("code_segment_out", oldest.code_segment_out,
						rsp.code_segment_out);
					check_field("instruction_pointer_out", oldest.instruction_pointer_out,
						rsp.instruction_pointer_out);
					check_field("flags_out", oldest.flags_out, rsp.flags_out);
					check_field("read_byte", {8'h00, oldest.read_byte}, {8'h00, rsp.read_byte});
					compared++;
				end
			end
			if (req_valid && req_ready)
				expected_images.push_back(predict_registers(req));
			pending = expected_images.size();
		end
	end

endmodule

// ===== tb/real_mode_interrupt_entry_return_tb.sv =====
// Testbench top for real-mode interrupt entry and return: stimulus, flow control and verdict.
module real_mode_interrupt_entry_return_tb;
	import rmie_pkg::*;

	localparam int          ITEM_TARGET    = 600;
	localparam int          CYCLE_LIMIT    = 1000000;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          DRAIN_CYCLES   = 30;
	localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
	localparam logic [2:0]  CMD_UNUSED_MID = 3'd6;
	localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int mismatches;
	int pending;
	int compared;
	int cycle_count   = 0;
	int counted_items = 0;
	int burst_left    = 0;
	int cmd_seen [8]  = '{default: 0};
	bit hold_armed    = 1'b0;
	bit hold_done     = 1'b0;

	// Stimulus-side view of the stack registers and of which bytes hold data
	logic [15:0]  gen_ss = '0;
	logic [15:0]  gen_sp = '0;
	bit           written [bit [19:0]];
	bit   [19:0]  written_list [$];

	always #4 clk = ~clk;

	real_mode_interrupt_entry_return uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	rmie_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [19:0] linear(input logic [15:0] seg, input logic [15:0] ofs);
		return {seg, 4'h0} + {4'h0, ofs};
	endfunction

	function automatic req_t random_fields();
		req_t r;
		r.cmd                     = 3'($urandom_range(0, 7));
		r.vector                  = 8'($urandom);
		r.address                 = 20'($urandom);
		r.data_byte               = 8'($urandom);
		r.new_stack_segment       = 16'($urandom);
		r.new_stack_pointer       = 16'($urandom);
		r.new_code_segment        = 16'($urandom);
		r.new_instruction_pointer = 16'($urandom);
		r.new_flags               = 16'($urandom);
		return r;
	endfunction

	function automatic logic [15:0] skewed_word();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'hFFFF;
		if (pick == 2)
			return 16'($urandom_range(0, 7));
		if (pick == 3)
			return 16'hFFF8 + 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_vector();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick < 2)
			return BRK_VECTOR;
		if (pick == 2)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	task automatic mark_written(input logic [19:0] a);
		if (!written.exists(a)) begin
			written[a] = 1'b1;
			written_list.push_back(a);
		end
	endtask

	// Offer one command in bursts separated by random gaps, then track what it changes
	task automatic issue(input req_t r);
		logic [19:0] a;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		case (r.cmd)
			CMD_INT: begin
				repeat (3) begin
					gen_sp = gen_sp - 16'd2;
					a = linear(gen_ss, gen_sp);
					mark_written(a);
					mark_written(a + 20'd1);
				end
			end
			CMD_IRET:  gen_sp = gen_sp + 16'd6;
			CMD_WRITE: mark_written(r.address);
			CMD_LOAD: begin
				gen_ss = r.new_stack_segment;
				gen_sp = r.new_stack_pointer;
			end
			default: ;
		endcase
		cmd_seen[r.cmd]++;
		if (r.cmd <= CMD_LOAD)
			counted_items++;
	endtask

	task automatic write_byte(input logic [19:0] a, input logic [7:0] d);
		req_t r;
		r = random_fields();
		r.cmd       = CMD_WRITE;
		r.address   = a;
		r.data_byte = d;
		issue(r);
	endtask

	task automatic ensure_written(input logic [19:0] a);
		if (!written.exists(a))
			write_byte(a, 8'($urandom));
	endtask

	task automatic read_byte_at(input logic [19:0] a);
		req_t r;
		ensure_written(a);
		r = random_fields();
		r.cmd     = CMD_READ;
		r.address = a;
		issue(r);
	endtask

	task automatic read_any_written();
		if (written_list.size() == 0)
			write_byte(20'($urandom), 8'($urandom));
		read_byte_at(written_list[$urandom_range(0, written_list.size() - 1)]);
	endtask

	task automatic load_regs(input logic [15:0] ss, input logic [15:0] sp, input logic [15:0] cs,
		input logic [15:0] ip, input logic [15:0] fl);
		req_t r;
		r = random_fields();
		r.cmd                     = CMD_LOAD;
		r.new_stack_segment       = ss;
		r.new_stack_pointer       = sp;
		r.new_code_segment        = cs;
		r.new_instruction_pointer = ip;
		r.new_flags               = fl;
		issue(r);
	endtask

	task automatic load_random();
		logic [15:0] sp;
		logic [15:0] cs;
		logic [15:0] ip;
		sp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 5)) : skewed_word();
		cs = ($urandom_range(0, 3) == 0) ? 16'hF000 + 16'($urandom_range(0, 4095)) : skewed_word();
		ip = ($urandom_range(0, 3) == 0) ? 16'hFFFE + 16'($urandom_range(0, 1)) : skewed_word();
		load_regs(skewed_word(), sp, cs, ip, skewed_word());
	endtask

	// Fill the vector entry first so the table fetch sees defined bytes
	task automatic interrupt(input logic [7:0] v);
		req_t        r;
		logic [19:0] base;
		base = {10'd0, v, 2'b00};
		for (int k = 0; k < 4; k++)
			ensure_written(base + 20'(k));
		r = random_fields();
		r.cmd    = CMD_INT;
		r.vector = v;
		issue(r);
	endtask

	// Fill any stack byte the pops will touch that holds no data yet
	task automatic interrupt_return();
		req_t        r;
		logic [15:0] p;
		p = gen_sp;
		repeat (3) begin
			ensure_written(linear(gen_ss, p));
			ensure_written(linear(gen_ss, p) + 20'd1);
			p = p + 16'd2;
		end
		r = random_fields();
		r.cmd = CMD_IRET;
		issue(r);
	endtask

	task automatic unused_code(input logic [2:0] code);
		req_t r;
		r = random_fields();
		r.cmd = code;
		issue(r);
	endtask

	// Nested entries with stack peeks, then mostly matching returns
	task automatic nested_frames();
		int depth;
		int rets;
		depth = $urandom_range(1, 3);
		if ($urandom_range(0, 1))
			load_random();
		for (int k = 0; k < depth; k++) begin
			interrupt(pick_vector());
			if ($urandom_range(0, 2) == 0)
				read_byte_at(linear(gen_ss, gen_sp) + 20'($urandom_range(0, 1)));
		end
		rets = depth;
		if ($urandom_range(0, 7) == 0)
			rets = depth + ($urandom_range(0, 1) ? 1 : -1);
		for (int k = 0; k < rets; k++)
			interrupt_return();
	endtask

	// Result-side flow control: random patterns plus one long hold-off
	initial begin
		int       seg;
		rx_mode_t mode;
		@(posedge arst_n);
		forever begin
			if (hold_armed && !hold_done) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					rsp_ready <= 1'b0;
				end
				hold_done = 1'b1;
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(10, 150);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   rsp_ready <= 1'b1;
					RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
					default:   rsp_ready <= ~rsp_ready;
				endcase
			end
		end
	end

	initial begin
		int start;
		int pick;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset state, then wraps of SP, IP and CS on a breakpoint entry
		unused_code(CMD_UNUSED_HI);
		load_regs(16'h0000, 16'h0000, 16'hF000, 16'hFFFF, 16'hFFFF);
		interrupt(BRK_VECTOR);
		interrupt_return();
		// Top of the vector table, IP carry on a two-byte step, nested with vector zero
		load_regs(16'h1234, 16'h0100, 16'hF000, 16'hFFFE, 16'h0300);
		interrupt(8'hFF);
		interrupt(8'h00);
		interrupt_return();
		interrupt_return();
		// Stack word straddling the top of the 1 MB space
		load_regs(16'hFFFF, 16'h0011, 16'h5555, 16'hAAAA, 16'h0000);
		interrupt(8'h80);
		read_byte_at(20'hFFFFF);
		read_byte_at(20'h00000);
		interrupt_return();
		// Alternating bit patterns through plain byte access
		write_byte(20'hAAAAA, 8'h55);
		write_byte(20'h55555, 8'hAA);
		read_byte_at(20'hAAAAA);
		read_byte_at(20'h55555);
		unused_code(CMD_UNUSED_LO);
		unused_code(CMD_UNUSED_MID);

		// Random part: well-formed interrupt frames mixed with loose commands
		hold_armed = 1'b1;
		start = counted_items;
		while (counted_items - start < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				nested_frames();
			else if (pick < 50)
				write_byte(($urandom_range(0, 9) == 0) ? 20'hFFFFF - 20'($urandom_range(0, 3))
					: 20'($urandom), 8'($urandom));
			else if (pick < 65)
				read_any_written();
			else if (pick < 73)
				load_random();
			else if (pick < 80)
				interrupt_return();
			else if (pick < 88)
				interrupt(pick_vector());
			else if (pick < 93)
				unused_code(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
			else
				write_byte(20'($urandom_range(0, 1023)), 8'($urandom));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Drain outstanding results, then watch for stray ones
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d interrupts, %0d returns, %0d writes, %0d reads,",
			cmd_seen[CMD_INT], cmd_seen[CMD_IRET], cmd_seen[CMD_WRITE], cmd_seen[CMD_READ]);
		$display("%0d loads, %0d unused codes; %0d results compared over %0d cycles, %0d-cycle stall",
			cmd_seen[CMD_LOAD], cmd_seen[CMD_UNUSED_LO] + cmd_seen[CMD_UNUSED_MID] +
			cmd_seen[CMD_UNUSED_HI], compared, cycle_count, HOLD_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
